>>> rtl/dpb_pkg.sv
// Shared types and constants for the int4/int8 block dot product.
package dpb_pkg;

    // Element lanes carried by one item
    localparam int BYTES_PER_ITEM = 4;
    localparam int SUM_W          = 32;
    localparam int LANE_SUM_W     = 14;

    localparam logic [3:0]  ZP_RESET    = 4'd8;
    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;

    // Floating-point unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_CVT
    } fp_op_t;

    // Steps of one block-pair close, low block first
    typedef enum logic [2:0] {
        STEP_SCALE_LO,
        STEP_CVT_LO,
        STEP_PROD_LO,
        STEP_ACC_LO,
        STEP_SCALE_HI,
        STEP_CVT_HI,
        STEP_PROD_HI,
        STEP_ACC_HI
    } step_t;

    // Controller to datapath
    typedef struct packed {
        logic  accept;
        logic  fp_start;
        step_t step;
        logic  clear_sums;
        logic  emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fp_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/dpb_fpu.sv
// Multi-cycle fp32 unit: multiply, add and int32 conversion, round to nearest even.
module dpb_fpu (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  dpb_pkg::fp_op_t op,
    input  logic [31:0]    a,
    input  logic [31:0]    b,
    output logic           done,
    output logic [31:0]    result
);
    import dpb_pkg::*;

    localparam int MW = 50;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ALIGN,
        F_SUM,
        F_NORM,
        F_ROUND
    } fstate_t;

    fstate_t            state_reg;
    logic               sign_reg;
    logic signed [11:0] exp_reg;
    logic [MW-1:0]      m_reg;
    logic               stk_reg;
    logic [23:0]        ma_reg;
    logic [23:0]        mb_reg;
    logic [7:0]         shamt_reg;
    logic               sub_reg;
    logic [MW-1:0]      bsh_reg;
    logic               done_reg;
    logic [31:0]        result_reg;

    // Operand decode for multiply and conversion
    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0] a_man, b_man;
    logic [7:0]  a_ee, b_ee;
    logic [31:0] a_mag;

    assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign a_zero = (a[30:0] == 31'd0);
    assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign b_zero = (b[30:0] == 31'd0);
    assign a_man  = {a[30:23] != 8'd0, a[22:0]};
    assign b_man  = {b[30:23] != 8'd0, b[22:0]};
    assign a_ee   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    assign b_ee   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    assign a_mag  = a[31] ? (~a + 32'd1) : a;

    // Add: x is the operand of larger magnitude
    logic        swap;
    logic [31:0] x, y;
    logic        x_inf, y_inf, x_zero, y_zero;
    logic [23:0] x_man, y_man;
    logic [7:0]  x_ee, y_ee;

    assign swap   = b[30:0] > a[30:0];
    assign x      = swap ? b : a;
    assign y      = swap ? a : b;
    assign x_inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    assign y_inf  = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    assign x_zero = (x[30:0] == 31'd0);
    assign y_zero = (y[30:0] == 31'd0);
    assign x_man  = {x[30:23] != 8'd0, x[22:0]};
    assign y_man  = {y[30:23] != 8'd0, y[22:0]};
    assign x_ee   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    assign y_ee   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];

    // Significand product
    logic [47:0] prod;
    assign prod = ma_reg * mb_reg;

    // Alignment shift with sticky
    logic [MW-1:0] afull, bfull, lost_mask, bsh, msum;
    assign afull     = {1'b0, ma_reg, 25'd0};
    assign bfull     = {1'b0, mb_reg, 25'd0};
    assign lost_mask = ~({MW{1'b1}} << shamt_reg);
    always_comb
    begin
        if (shamt_reg >= 8'(MW))
        begin
            bsh = {{(MW-1){1'b0}}, 1'b1};
        end
        else
        begin
            bsh = (bfull >> shamt_reg) | {{(MW-1){1'b0}}, |(bfull & lost_mask)};
        end
    end
    assign msum = sub_reg ? (afull - bsh_reg) : (afull + bsh_reg);

    // Rounding and packing
    logic [23:0]        q, qf;
    logic               g, st, inc;
    logic [24:0]        q25;
    logic signed [11:0] exp_r;
    logic [31:0]        rounded;

    assign q     = m_reg[MW-1:MW-24];
    assign g     = m_reg[MW-25];
    assign st    = (|m_reg[MW-26:0]) | stk_reg;
    assign inc   = g & (st | q[0]);
    assign q25   = {1'b0, q} + {24'd0, inc};
    assign exp_r = q25[24] ? (exp_reg + 12'sd1) : exp_reg;
    assign qf    = q25[24] ? q25[24:1] : q25[23:0];
    always_comb
    begin
        if (exp_r >= 12'sd255)
        begin
            rounded = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            rounded = {sign_reg, (qf[23] ? exp_r[7:0] : 8'h00), qf[22:0]};
        end
    end

    // Sequencer and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        case (op)
                            OP_MUL:
                            begin
                                sign_reg <= a[31] ^ b[31];
                                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
                                begin
                                    result_reg <= FP_QNAN;
                                    done_reg   <= 1'b1;
                                end
                                else if (a_inf || b_inf)
                                begin
                                    result_reg <= {a[31] ^ b[31], 8'hFF, 23'd0};
                                    done_reg   <= 1'b1;
                                end
                                else if (a_zero || b_zero)
                                begin
                                    result_reg <= {a[31] ^ b[31], 31'd0};
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    ma_reg    <= a_man;
                                    mb_reg    <= b_man;
                                    exp_reg   <= $signed({4'd0, a_ee}) + $signed({4'd0, b_ee})
                                                 - 12'sd126;
                                    state_reg <= F_MUL;
                                end
                            end
                            OP_ADD:
                            begin
                                sign_reg <= x[31];
                                if (a_nan || b_nan || (x_inf && y_inf && (x[31] != y[31])))
                                begin
                                    result_reg <= FP_QNAN;
                                    done_reg   <= 1'b1;
                                end
                                else if (x_inf)
                                begin
                                    result_reg <= x;
                                    done_reg   <= 1'b1;
                                end
                                else if (x_zero)
                                begin
                                    result_reg <= {x[31] & y[31], 31'd0};
                                    done_reg   <= 1'b1;
                                end
                                else if (y_zero)
                                begin
                                    result_reg <= x;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    ma_reg    <= x_man;
                                    mb_reg    <= y_man;
                                    shamt_reg <= x_ee - y_ee;
                                    sub_reg   <= x[31] ^ y[31];
                                    exp_reg   <= $signed({4'd0, x_ee}) + 12'sd1;
                                    state_reg <= F_ALIGN;
                                end
                            end
                            OP_CVT:
                            begin
                                sign_reg <= a[31];
                                if (a == 32'd0)
                                begin
                                    result_reg <= FP_POS_ZERO;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    m_reg     <= {a_mag, 18'd0};
                                    stk_reg   <= 1'b0;
                                    exp_reg   <= 12'sd158;
                                    state_reg <= F_NORM;
                                end
                            end
                            default:
                            begin
                                result_reg <= FP_QNAN;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                F_MUL:
                begin
                    m_reg     <= {prod, 2'b00};
                    stk_reg   <= 1'b0;
                    state_reg <= F_NORM;
                end
                F_ALIGN:
                begin
                    bsh_reg   <= bsh;
                    state_reg <= F_SUM;
                end
                F_SUM:
                begin
                    m_reg     <= msum;
                    stk_reg   <= 1'b0;
                    state_reg <= F_NORM;
                end
                F_NORM:
                begin
                    // one bit a cycle, stopping at the subnormal boundary
                    if ((m_reg == '0) && !stk_reg)
                    begin
                        result_reg <= FP_POS_ZERO;
                        done_reg   <= 1'b1;
                        state_reg  <= F_IDLE;
                    end
                    else if (exp_reg < 12'sd1)
                    begin
                        if (m_reg == '0)
                        begin
                            exp_reg <= 12'sd1;
                        end
                        else
                        begin
                            m_reg   <= m_reg >> 1;
                            stk_reg <= stk_reg | m_reg[0];
                            exp_reg <= exp_reg + 12'sd1;
                        end
                    end
                    else if ((exp_reg > 12'sd1) && !m_reg[MW-1])
                    begin
                        m_reg   <= m_reg << 1;
                        exp_reg <= exp_reg - 12'sd1;
                    end
                    else
                    begin
                        state_reg <= F_ROUND;
                    end
                end
                F_ROUND:
                begin
                    result_reg <= rounded;
                    done_reg   <= 1'b1;
                    state_reg  <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/dpb_datapath.sv
// Datapath: integer block sums, fp operand routing, accumulator and result register.
module dpb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  dpb_pkg::dp_cmd_t    cmd,
    output dpb_pkg::dp_status_t status,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    input  logic [31:0]         weight_bytes,
    input  logic [31:0]         act_low_group,
    input  logic [31:0]         act_high_group,
    input  logic [31:0]         w_scale_low,
    input  logic [31:0]         a_scale_low,
    input  logic [31:0]         w_scale_high,
    input  logic [31:0]         a_scale_high,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         dot_result
);
    import dpb_pkg::*;

    logic [3:0]              zp_reg;
    logic signed [SUM_W-1:0] sum_lo_reg, sum_hi_reg;
    logic [31:0]             acc_reg, t_reg, u_reg;
    logic [31:0]             ws_lo_reg, as_lo_reg, ws_hi_reg, as_hi_reg;
    logic                    out_valid_reg;
    logic [31:0]             out_data_reg;

    // Four lanes of (code - zero point) * activation
    function automatic logic signed [LANE_SUM_W-1:0] group_sum(
        input logic [31:0] w,
        input logic [31:0] act,
        input logic        hi,
        input logic [3:0]  zp
    );
        logic [3:0]                   nib;
        logic signed [4:0]            d;
        logic signed [LANE_SUM_W-1:0] dd, aa, acc;
        acc = '0;
        for (int i = 0; i < BYTES_PER_ITEM; i++)
        begin
            nib = hi ? w[8*i+4 +: 4] : w[8*i +: 4];
            d   = $signed({1'b0, nib}) - $signed({1'b0, zp});
            dd  = {{(LANE_SUM_W-5){d[4]}}, d};
            aa  = {{(LANE_SUM_W-8){act[8*i+7]}}, act[8*i +: 8]};
            acc = acc + dd * aa;
        end
        return acc;
    endfunction

    logic signed [LANE_SUM_W-1:0] lane_lo, lane_hi;
    assign lane_lo = group_sum(weight_bytes, act_low_group, 1'b0, zp_reg);
    assign lane_hi = group_sum(weight_bytes, act_high_group, 1'b1, zp_reg);

    // Operand routing for the current close step
    fp_op_t      fp_op;
    logic [31:0] fp_a, fp_b, fp_res;
    logic        fp_done;

    always_comb
    begin
        case (cmd.step)
            STEP_SCALE_LO: begin fp_op = OP_MUL; fp_a = ws_lo_reg;  fp_b = as_lo_reg; end
            STEP_CVT_LO:   begin fp_op = OP_CVT; fp_a = sum_lo_reg; fp_b = '0;        end
            STEP_PROD_LO:  begin fp_op = OP_MUL; fp_a = u_reg;      fp_b = t_reg;     end
            STEP_ACC_LO:   begin fp_op = OP_ADD; fp_a = acc_reg;    fp_b = t_reg;     end
            STEP_SCALE_HI: begin fp_op = OP_MUL; fp_a = ws_hi_reg;  fp_b = as_hi_reg; end
            STEP_CVT_HI:   begin fp_op = OP_CVT; fp_a = sum_hi_reg; fp_b = '0;        end
            STEP_PROD_HI:  begin fp_op = OP_MUL; fp_a = u_reg;      fp_b = t_reg;     end
            STEP_ACC_HI:   begin fp_op = OP_ADD; fp_a = acc_reg;    fp_b = t_reg;     end
            default:       begin fp_op = OP_MUL; fp_a = '0;         fp_b = '0;        end
        endcase
    end

    dpb_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fp_start),
        .op     (fp_op),
        .a      (fp_a),
        .b      (fp_b),
        .done   (fp_done),
        .result (fp_res)
    );

    // NaN leaves the block in canonical form
    logic [31:0] acc_out;
    assign acc_out = ((acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != 23'd0)) ? FP_QNAN : acc_reg;

    // Control state: zero point, sums, accumulator, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zp_reg        <= ZP_RESET;
            sum_lo_reg    <= '0;
            sum_hi_reg    <= '0;
            acc_reg       <= FP_POS_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                zp_reg <= cfg_data;
            end
            if (cmd.clear_sums)
            begin
                sum_lo_reg <= '0;
                sum_hi_reg <= '0;
            end
            else if (cmd.accept)
            begin
                sum_lo_reg <= sum_lo_reg + SUM_W'(lane_lo);
                sum_hi_reg <= sum_hi_reg + SUM_W'(lane_hi);
            end
            if (cmd.emit)
            begin
                acc_reg <= FP_POS_ZERO;
            end
            else if (fp_done && ((cmd.step == STEP_ACC_LO) || (cmd.step == STEP_ACC_HI)))
            begin
                acc_reg <= fp_res;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ws_lo_reg <= w_scale_low;
            as_lo_reg <= a_scale_low;
            ws_hi_reg <= w_scale_high;
            as_hi_reg <= a_scale_high;
        end
        if (fp_done)
        begin
            case (cmd.step)
                STEP_CVT_LO, STEP_CVT_HI:     u_reg <= fp_res;
                STEP_SCALE_LO, STEP_SCALE_HI,
                STEP_PROD_LO, STEP_PROD_HI:   t_reg <= fp_res;
                default:                      ;
            endcase
        end
        if (cmd.emit)
        begin
            out_data_reg <= acc_out;
        end
    end

    assign status.fp_done  = fp_done;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign dot_result      = out_data_reg;

endmodule

>>> rtl/dpb_ctrl.sv
// Controller: item acceptance and sequencing of the block-pair close.
module dpb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                block_pair_end,
    input  logic                dot_end,
    input  dpb_pkg::dp_status_t status,
    output dpb_pkg::dp_cmd_t    cmd
);
    import dpb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_EMIT
    } state_t;

    state_t state_reg;
    step_t  step_reg;
    logic   start_reg;
    logic   dend_reg;

    logic accept;
    logic last_done;
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign last_done = (state_reg == S_BUSY) && status.fp_done && (step_reg == STEP_ACC_HI);

    // State, step and start pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_SCALE_LO;
            start_reg <= 1'b0;
            dend_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (block_pair_end || dot_end))
                    begin
                        dend_reg  <= dot_end;
                        step_reg  <= STEP_SCALE_LO;
                        start_reg <= 1'b1;
                        state_reg <= S_BUSY;
                    end
                end
                S_BUSY:
                begin
                    if (status.fp_done)
                    begin
                        if (step_reg == STEP_ACC_HI)
                        begin
                            state_reg <= dend_reg ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            step_reg  <= step_t'(step_reg + 3'd1);
                            start_reg <= 1'b1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign cmd.accept     = accept;
    assign cmd.fp_start   = start_reg;
    assign cmd.step       = step_reg;
    assign cmd.clear_sums = last_done;
    assign cmd.emit       = (state_reg == S_EMIT) && status.out_free;

endmodule

>>> rtl/int4_int8_block_dot_product.sv
// Top level: int4 weight by int8 activation block dot product with fp32 scaling.
// An item without a block-pair or dot end leaves the input open; the next item may follow at once.
// A closing item runs four fp32 operations per block (two multiplies, a conversion, an add)
// on one shared iterative unit, whose normalising shifter moves one bit at a time.
// On a dot end the controller enters its emit state after the last add and registers the result once
// the previous one is not stalled; the input is stalled throughout the close. Reset clears sums,
// accumulator (+0) and output valid, and sets the zero point to 8.
module int4_int8_block_dot_product (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] weight_bytes,
    input  logic [31:0] act_low_group,
    input  logic [31:0] act_high_group,
    input  logic [31:0] w_scale_low,
    input  logic [31:0] a_scale_low,
    input  logic [31:0] w_scale_high,
    input  logic [31:0] a_scale_high,
    input  logic        block_pair_end,
    input  logic        dot_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] dot_result
);
    import dpb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    dpb_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .block_pair_end (block_pair_end),
        .dot_end        (dot_end),
        .status         (status),
        .cmd            (cmd)
    );

    dpb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid & cfg_ready),
        .cfg_data       (cfg_data),
        .weight_bytes   (weight_bytes),
        .act_low_group  (act_low_group),
        .act_high_group (act_high_group),
        .w_scale_low    (w_scale_low),
        .a_scale_low    (a_scale_low),
        .w_scale_high   (w_scale_high),
        .a_scale_high   (a_scale_high),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dot_result     (dot_result)
    );

endmodule

>>> rtl/dpb_checker.sv
// Port-level checks for the block dot product, bound to the top level.
module dpb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        block_pair_end,
    input logic        dot_end,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] dot_result
);

    // A held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dot_result))
        else $error("result changed while stalled");

    // A plain item leaves the input open
    a_plain_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !block_pair_end && !dot_end |=> !in_stall)
        else $error("input stalled after a plain item");

    // A closing item stalls the input for the close
    a_close_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (block_pair_end || dot_end) |=> in_stall)
        else $error("input open during block close");

    // A new result only appears at the end of a close
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a close");

endmodule

bind int4_int8_block_dot_product dpb_checker u_dpb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .block_pair_end (block_pair_end),
    .dot_end        (dot_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dot_result     (dot_result)
);
